// ===== sv/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Types and codes shared by the timing wheel scheduler modules.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int TIME_W  = 32;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int ID_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_FIRED     = 3'd4,
        KIND_TICK_DONE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_TICK_CHK,
        S_TICK_DONE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] target;
        logic [TIME_W-1:0] period;
        logic              repeat_flag;
    } slot_entry_t;

endpackage

// ===== sv/tws_req_if.sv =====
// ----------------------------------------------------------------------------
// tws_req_if
// Command channel: one item per add, cancel or tick command.
// ----------------------------------------------------------------------------
interface tws_req_if;

    logic                      valid;
    logic                      ready;
    logic [tws_pkg::CMD_W-1:0] cmd;
    logic [31:0]               delay_ticks;
    logic                      repeat_req;
    logic [tws_pkg::ID_W-1:0]  task_id;

    modport source (
        output valid,
        output cmd,
        output delay_ticks,
        output repeat_req,
        output task_id,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  delay_ticks,
        input  repeat_req,
        input  task_id,
        output ready
    );

endinterface

// ===== sv/tws_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tws_rsp_if
// Result channel: one item per result of a command.
// ----------------------------------------------------------------------------
interface tws_rsp_if;

    logic                       valid;
    logic                       ready;
    logic [tws_pkg::KIND_W-1:0] kind;
    logic [tws_pkg::ID_W-1:0]   task_id_res;
    logic                       last;

    modport source (
        output valid,
        output kind,
        output task_id_res,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  task_id_res,
        input  last,
        output ready
    );

endinterface

// ===== sv/tws_slot_mem.sv =====
// ----------------------------------------------------------------------------
// tws_slot_mem
// Slot table: target, period and repeat flag per slot. One write port, one
// read port, registered read data.
// ----------------------------------------------------------------------------
module tws_slot_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  tws_pkg::slot_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output tws_pkg::slot_entry_t rd_data
);

    tws_pkg::slot_entry_t mem [DEPTH];
    tws_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/timing_wheel_scheduler.sv =====
// ----------------------------------------------------------------------------
// timing_wheel_scheduler
// Timer table of MAX_TASKS slots with add, cancel and tick commands.
// ----------------------------------------------------------------------------
// One command is worked on at a time. An add scans the slot valid bits one
// slot per cycle from slot 0; a tick walks the slot memory through its single
// read port, one slot per cycle while the result channel does not stall. A
// new command is accepted while the last result still waits in the output
// register. Slot contents are undefined until an add writes them; a tick
// reads every slot, but the contents of invalid slots are never used.
module timing_wheel_scheduler #(
    parameter int MAX_TASKS = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    tws_req_if.sink   req,
    tws_rsp_if.source rsp
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TASKS - 1);

    tws_pkg::state_t         state_reg, state_next;
    logic [MAX_TASKS-1:0]    valid_reg, valid_next;
    logic [31:0]             time_reg, time_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [31:0]             delay_reg, delay_next;
    logic                    rep_reg, rep_next;
    tws_pkg::kind_t          pend_kind_reg, pend_kind_next;
    logic [IDX_W-1:0]        pend_id_reg, pend_id_next;

    logic                    out_valid_reg, out_valid_next;
    tws_pkg::kind_t          out_kind_reg, out_kind_next;
    logic [tws_pkg::ID_W-1:0] out_id_reg, out_id_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic                    req_acc;
    logic [IDX_W-1:0]        cancel_idx;
    logic                    cancel_hit;
    logic                    fire;
    logic [31:0]             period_eff;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    tws_pkg::slot_entry_t    wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    tws_pkg::slot_entry_t    rd_data;

    tws_slot_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free   = !out_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == tws_pkg::S_IDLE);
    assign req_acc    = req.valid && req.ready;
    assign cancel_idx = IDX_W'(req.task_id);
    assign cancel_hit = ({27'd0, req.task_id} < 32'(MAX_TASKS)) && valid_reg[cancel_idx];
    assign fire       = valid_reg[idx_reg] && (rd_data.target == time_reg);
    assign period_eff = (rd_data.period == 32'd0) ? 32'd1 : rd_data.period;

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        time_next      = time_reg;
        idx_next       = idx_reg;
        delay_next     = delay_reg;
        rep_next       = rep_reg;
        pend_kind_next = pend_kind_reg;
        pend_id_next   = pend_id_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '{target: time_reg + delay_reg, period: delay_reg,
                           repeat_flag: rep_reg};
        rd_en          = 1'b0;
        rd_addr        = idx_reg + IDX_W'(1);

        unique case (state_reg)
            tws_pkg::S_IDLE:
            begin
                rd_addr = '0;
                if (req_acc)
                begin
                    delay_next = req.delay_ticks;
                    rep_next   = req.repeat_req;
                    idx_next   = '0;
                    case (req.cmd)
                        tws_pkg::CMD_ADD:
                        begin
                            state_next = tws_pkg::S_ADD_SCAN;
                        end
                        tws_pkg::CMD_CANCEL:
                        begin
                            if (cancel_hit)
                            begin
                                valid_next[cancel_idx] = 1'b0;
                                pend_kind_next         = tws_pkg::KIND_CANCELLED;
                                pend_id_next           = cancel_idx;
                            end
                            else
                            begin
                                pend_kind_next = tws_pkg::KIND_NOT_FOUND;
                                pend_id_next   = '0;
                            end
                            state_next = tws_pkg::S_RESP;
                        end
                        tws_pkg::CMD_TICK:
                        begin
                            rd_en      = 1'b1;
                            state_next = tws_pkg::S_TICK_CHK;
                        end
                        default:
                        begin
                            state_next = tws_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            tws_pkg::S_ADD_SCAN:
            begin
                if (!valid_reg[idx_reg])
                begin
                    valid_next[idx_reg] = 1'b1;
                    wr_en               = 1'b1;
                    pend_kind_next      = tws_pkg::KIND_ADDED;
                    pend_id_next        = idx_reg;
                    state_next          = tws_pkg::S_RESP;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    pend_kind_next = tws_pkg::KIND_FULL;
                    pend_id_next   = '0;
                    state_next     = tws_pkg::S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            tws_pkg::S_TICK_CHK:
            begin
                if (!fire || out_free)
                begin
                    if (fire)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = tws_pkg::KIND_FIRED;
                        out_id_next    = tws_pkg::ID_W'(idx_reg);
                        out_last_next  = 1'b0;
                        if (rd_data.repeat_flag)
                        begin
                            wr_en   = 1'b1;
                            wr_data = '{target: time_reg + period_eff,
                                        period: rd_data.period,
                                        repeat_flag: 1'b1};
                        end
                        else
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = tws_pkg::S_TICK_DONE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            tws_pkg::S_TICK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = tws_pkg::KIND_TICK_DONE;
                    out_id_next    = '0;
                    out_last_next  = 1'b1;
                    time_next      = time_reg + 32'd1;
                    state_next     = tws_pkg::S_IDLE;
                end
            end

            tws_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_id_next    = tws_pkg::ID_W'(pend_id_reg);
                    out_last_next  = 1'b1;
                    state_next     = tws_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tws_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tws_pkg::S_IDLE;
            valid_reg     <= '0;
            time_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            time_reg      <= time_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg     <= delay_next;
        rep_reg       <= rep_next;
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.task_id_res = out_id_reg;
    assign rsp.last        = out_last_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> $stable(out_kind_reg) && $stable(out_id_reg)
            && $stable(out_last_reg) && out_valid_reg)
        else $error("result changed while stalled");

    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tws_pkg::S_TICK_DONE) && out_free
            |=> time_reg == $past(time_reg) + 32'd1)
        else $error("time did not advance after tick");

    a_cancel_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req.cmd == tws_pkg::CMD_CANCEL) && cancel_hit
            |=> !valid_reg[$past(cancel_idx)])
        else $error("cancelled slot still valid");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg == tws_pkg::KIND_FIRED) |-> !out_last_reg)
        else $error("fired result marked last");

endmodule

// ===== tb/timing_wheel_scheduler_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timing_wheel_scheduler_checker
// Watches the command and result channels of the timer table, predicts the
// results of every accepted command from a private copy of the slot table
// and the tick counter, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module timing_wheel_scheduler_checker #(
    parameter int MAX_TASKS = 32
) (
    input  logic clk,
    input  logic rst_n,
    tws_req_if   req,
    tws_rsp_if   rsp,
    output int   errors,
    output int   pending
);

    typedef struct {
        tws_pkg::kind_t           kind;
        logic [tws_pkg::ID_W-1:0] id;
        logic                     last;
    } timer_result_t;

    timer_result_t     timer_result_q[$];

    logic                       slot_armed  [MAX_TASKS];
    logic [tws_pkg::TIME_W-1:0] slot_due    [MAX_TASKS];
    logic [tws_pkg::TIME_W-1:0] slot_every  [MAX_TASKS];
    logic                       slot_rearm  [MAX_TASKS];
    logic [tws_pkg::TIME_W-1:0] tick_now;

    function automatic void push_result(tws_pkg::kind_t kind,
                                        logic [tws_pkg::ID_W-1:0] id, logic last);
        timer_result_t r;
        r.kind = kind;
        r.id   = id;
        r.last = last;
        timer_result_q.push_back(r);
    endfunction

    task automatic predict_command(
        input logic [tws_pkg::CMD_W-1:0]  cmd,
        input logic [tws_pkg::TIME_W-1:0] delay,
        input logic                       rep,
        input logic [tws_pkg::ID_W-1:0]   id
    );
        bit                         placed;
        logic [tws_pkg::TIME_W-1:0] step;
        placed = 1'b0;
        case (cmd)
            tws_pkg::CMD_ADD:
            begin
                for (int s = 0; s < MAX_TASKS; s++)
                begin
                    if (!placed && !slot_armed[s])
                    begin
                        slot_armed[s] = 1'b1;
                        slot_due[s]   = tick_now + delay;
                        slot_every[s] = delay;
                        slot_rearm[s] = rep;
                        placed        = 1'b1;
                        push_result(tws_pkg::KIND_ADDED, tws_pkg::ID_W'(s), 1'b1);
                    end
                end
                if (!placed)
                    push_result(tws_pkg::KIND_FULL, '0, 1'b1);
            end
            tws_pkg::CMD_CANCEL:
            begin
                if (int'(id) < MAX_TASKS && slot_armed[id])
                begin
                    slot_armed[id] = 1'b0;
                    push_result(tws_pkg::KIND_CANCELLED, id, 1'b1);
                end
                else
                begin
                    push_result(tws_pkg::KIND_NOT_FOUND, '0, 1'b1);
                end
            end
            tws_pkg::CMD_TICK:
            begin
                for (int s = 0; s < MAX_TASKS; s++)
                begin
                    if (slot_armed[s] && slot_due[s] == tick_now)
                    begin
                        push_result(tws_pkg::KIND_FIRED, tws_pkg::ID_W'(s), 1'b0);
                        if (slot_rearm[s])
                        begin
                            step        = (slot_every[s] == '0) ? tws_pkg::TIME_W'(1)
                                                                : slot_every[s];
                            slot_due[s] = tick_now + step;
                        end
                        else
                        begin
                            slot_armed[s] = 1'b0;
                        end
                    end
                end
                push_result(tws_pkg::KIND_TICK_DONE, '0, 1'b1);
                tick_now = tick_now + 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result();
        timer_result_t want;
        int            bad;
        bad = 0;
        if (timer_result_q.size() == 0)
        begin
            $error("unexpected result: kind %0d, task_id_res %0d, last %0d",
                   rsp.kind, rsp.task_id_res, rsp.last);
            bad = 1;
        end
        else
        begin
            want = timer_result_q.pop_front();
            if (rsp.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
                bad++;
            end
            if (rsp.task_id_res !== want.id)
            begin
                $error("task_id_res: expected %0d, got %0d", want.id, rsp.task_id_res);
                bad++;
            end
            if (rsp.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, rsp.last);
                bad++;
            end
        end
        errors <= errors + bad;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_TASKS; s++)
            begin
                slot_armed[s] = 1'b0;
                slot_due[s]   = '0;
                slot_every[s] = '0;
                slot_rearm[s] = 1'b0;
            end
            tick_now = '0;
            timer_result_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_command(req.cmd, req.delay_ticks, req.repeat_req, req.task_id);
            if (rsp.valid && rsp.ready)
                check_result();
            pending <= timer_result_q.size();
        end
    end

endmodule

// ===== tb/timing_wheel_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timing_wheel_scheduler_tb
// Drives add, cancel, tick and unused command codes into the timer table: a directed
// opening, then random segments of mixed traffic, table fills and tick
// bursts, with random gaps on both channels and one long result stall.
// ----------------------------------------------------------------------------
module timing_wheel_scheduler_tb;

    localparam int MAX_TASKS    = 32;
    localparam int N_ITEMS      = 500;
    localparam int IDLE_MAX     = 18;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = MAX_TASKS + 10;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam logic [tws_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   sent;
    int   cycles;
    int   rsp_stall;
    bit   req_idle_on;
    bit   rsp_idle_on;
    bit   hold_off;

    tws_req_if req_ch ();
    tws_rsp_if rsp_ch ();

    timing_wheel_scheduler #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    timing_wheel_scheduler_checker #(
        .MAX_TASKS (MAX_TASKS)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [tws_pkg::TIME_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 24);
        else if (r < 92)
            return $urandom;
        else
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endfunction

    task automatic send_cmd(
        input logic [tws_pkg::CMD_W-1:0]  cmd,
        input logic [tws_pkg::TIME_W-1:0] delay,
        input logic                       rep,
        input logic [tws_pkg::ID_W-1:0]   id
    );
        int gap;
        gap = (req_idle_on && !hold_off) ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= cmd;
        req_ch.delay_ticks <= delay;
        req_ch.repeat_req  <= rep;
        req_ch.task_id     <= id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (cmd != CMD_UNUSED)
            sent++;
    endtask

    // result side: random stall after each item, forced low during reset and the hold
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall = 0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_stall = rsp_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (rsp_stall > 0)
                rsp_ch.ready <= 1'b0;
        end
        else if (rsp_stall > 1)
        begin
            rsp_stall = rsp_stall - 1;
        end
        else
        begin
            rsp_stall = 0;
            rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        hold_off <= 1'b0;
        wait (sent >= HOLD_AT);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int seg;
        int r;
        sent               = 0;
        req_idle_on        = 1'b1;
        rsp_idle_on        = 1'b1;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = tws_pkg::CMD_TICK;
        req_ch.delay_ticks = '0;
        req_ch.repeat_req  = 1'b0;
        req_ch.task_id     = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(tws_pkg::CMD_TICK,   '0,            1'b0, '0);
        send_cmd(tws_pkg::CMD_CANCEL, '0,            1'b0, 5'd0);
        send_cmd(tws_pkg::CMD_CANCEL, '1,            1'b1, 5'd31);
        send_cmd(tws_pkg::CMD_ADD,    '0,            1'b0, '0);
        send_cmd(tws_pkg::CMD_ADD,    '0,            1'b1, '0);
        send_cmd(tws_pkg::CMD_ADD,    32'hFFFF_FFFF, 1'b1, '1);
        send_cmd(tws_pkg::CMD_ADD,    32'd1,         1'b0, '0);
        send_cmd(CMD_UNUSED,          '1,            1'b1, '1);
        send_cmd(tws_pkg::CMD_TICK,   '1,            1'b1, '1);
        send_cmd(tws_pkg::CMD_TICK,   '0,            1'b0, '0);
        send_cmd(tws_pkg::CMD_CANCEL, '0,            1'b0, 5'd1);
        send_cmd(tws_pkg::CMD_CANCEL, '0,            1'b0, 5'd1);
        send_cmd(tws_pkg::CMD_ADD,    32'h8000_0000, 1'b0, '0);
        send_cmd(tws_pkg::CMD_CANCEL, '0,            1'b0, 5'd2);
        send_cmd(tws_pkg::CMD_ADD,    32'd3,         1'b1, '0);
        send_cmd(tws_pkg::CMD_TICK,   '0,            1'b0, '0);
        send_cmd(tws_pkg::CMD_TICK,   '0,            1'b0, '0);
        send_cmd(tws_pkg::CMD_TICK,   '0,            1'b0, '0);

        while (sent < N_ITEMS)
        begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            seg = $urandom_range(0, 9);
            if (seg < 2)
            begin
                repeat (MAX_TASKS + 2)
                    send_cmd(tws_pkg::CMD_ADD, pick_delay(), 1'($urandom_range(0, 1)),
                             tws_pkg::ID_W'($urandom));
            end
            else if (seg < 3)
            begin
                repeat ($urandom_range(8, 40))
                    send_cmd(tws_pkg::CMD_TICK, $urandom, 1'($urandom),
                             tws_pkg::ID_W'($urandom));
            end
            else
            begin
                repeat (40)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        send_cmd(tws_pkg::CMD_ADD, pick_delay(), ($urandom_range(0, 9) < 3),
                                 tws_pkg::ID_W'($urandom));
                    else if (r < 60)
                        send_cmd(tws_pkg::CMD_CANCEL, $urandom, 1'($urandom),
                                 tws_pkg::ID_W'($urandom_range(0, 31)));
                    else if (r < 97)
                        send_cmd(tws_pkg::CMD_TICK, $urandom, 1'($urandom),
                                 tws_pkg::ID_W'($urandom));
                    else
                        send_cmd(CMD_UNUSED, $urandom, 1'($urandom),
                                 tws_pkg::ID_W'($urandom));
                end
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tws_pkg.sv
sv/tws_req_if.sv
sv/tws_rsp_if.sv
sv/tws_slot_mem.sv
sv/timing_wheel_scheduler.sv
tb/timing_wheel_scheduler_checker.sv
tb/timing_wheel_scheduler_tb.sv
